@@ src/tzcp_pkg.sv @@
// Shared types, constants and the neighbour offset table for the zero-crossing point extractor.
// Used by tzcp_ctrl, tzcp_dp and tsdf_zero_crossing_points; depends on nothing.
package tzcp_pkg;

	// Default sizes of the voxel volume and the empty-voxel marker.
	localparam int DEF_MAX_X          = 64;
	localparam int DEF_MAX_Y          = 64;
	localparam int DEF_MAX_Z          = 64;
	localparam int DEF_EMPTY_SENTINEL = 32767;

	// Field widths.
	localparam int POS_W   = 6;
	localparam int CRD_W   = 7;   // neighbour coordinate, one above a position
	localparam int DIST_W  = 16;
	localparam int WGT_W   = 15;
	localparam int MAG_W   = 16;
	localparam int CELL_W  = 16;
	localparam int DIM_W   = 7;
	localparam int PT_W    = 24;
	localparam int CA_W    = 24;
	localparam int NUM_W   = 40;
	localparam int DEN_W   = 18;
	localparam int DIV_STEPS = NUM_W;
	localparam int DCNT_W  = $clog2(DIV_STEPS);
	localparam int NB_W    = 4;
	localparam int NB_NARROW = 3;
	localparam int NB_WIDE   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 72;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DIM_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_Z  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE    = 3'd6;

	// Register reset values.
	localparam logic [DIM_W-1:0]  RST_DIM  = 7'd64;
	localparam logic [CELL_W-1:0] RST_CELL = 16'd3072;

	// Input word kinds.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SCAN  = 1'b1;

	// Axis selectors.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_WRITE,
		OP_LOAD,
		OP_RD_CEN,
		OP_CEN_LATCH,
		OP_RD_NB,
		OP_NB_LATCH,
		OP_MUL_CA,
		OP_MUL_CB,
		OP_MUL_NA,
		OP_MUL_NB,
		OP_DIV,
		OP_DIV_END,
		OP_PUSH,
		OP_FLUSH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic [NB_W-1:0] nb;
	} ctrl_cmd_t;

	typedef struct packed {
		logic interior;
		logic centre_ok;
		logic crossing;
		logic nb_last;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic [DIM_W-1:0]  dim_x;
		logic [DIM_W-1:0]  dim_y;
		logic [DIM_W-1:0]  dim_z;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [CELL_W-1:0] cell_z;
		logic              wide;
	} cfg_t;

	typedef struct packed {
		logic signed [1:0] dx;
		logic signed [1:0] dy;
		logic signed [1:0] dz;
	} offset_t;

	// Forward neighbour offsets: three axis neighbours, or thirteen in wide mode.
	function automatic offset_t nb_offset(input logic wide, input logic [NB_W-1:0] idx);
		offset_t o;
		o = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
		if (!wide) begin
			case (idx)
				4'd0:    o = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd0};
				4'd1:    o = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd0};
				default: o = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd1};
			endcase
		end else begin
			case (idx)
				4'd0:    o = '{dx: -2'sd1, dy: -2'sd1, dz:  2'sd1};
				4'd1:    o = '{dx:  2'sd0, dy: -2'sd1, dz:  2'sd1};
				4'd2:    o = '{dx:  2'sd1, dy: -2'sd1, dz:  2'sd1};
				4'd3:    o = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd1};
				4'd4:    o = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd1};
				4'd5:    o = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd1};
				4'd6:    o = '{dx: -2'sd1, dy:  2'sd1, dz:  2'sd1};
				4'd7:    o = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd1};
				4'd8:    o = '{dx:  2'sd1, dy:  2'sd1, dz:  2'sd1};
				4'd9:    o = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd0};
				4'd10:   o = '{dx: -2'sd1, dy:  2'sd1, dz:  2'sd0};
				4'd11:   o = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd0};
				default: o = '{dx:  2'sd1, dy:  2'sd1, dz:  2'sd0};
			endcase
		end
		return o;
	endfunction

endpackage

@@ src/tsdf_zero_crossing_points.sv @@
// Top level of the zero-crossing point extractor: configuration registers and the
// controller and datapath. Depends on tzcp_pkg, tzcp_ctrl and tzcp_dp.
//
// Usage. Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser selects a
// voxel write (0) or a scan (1). Writes load one voxel of the store; load the whole
// volume before scanning. A scan word yields zero to thirteen surface points on
// m_tvalid/m_tready/m_tdata, with m_tlast on the final point of that scan.
// Registers are to be written by the user on cfg_valid/cfg_ready (always ready) only
// while idle; the block itself does not enforce this. A scan outside the interior
// ends at the centre read, one with an unusable centre at the centre check.
// Otherwise each neighbour is read and checked; each crossing runs three axes of
// four shared-multiplier steps, a division of one quotient bit per cycle and a
// result step, then a push of the held point; a flush step ends the scan. The
// divider loop sets the cost of a crossing; memory reads set the rest.
// Each point is held until the next crossing or the end of the scan decides its
// last flag, then moves to the output register; new input words are taken while
// that register still waits. When the receiver stalls, the scan waits on the held
// point. Reset clears control and registers; the voxel store is not cleared.
module tsdf_zero_crossing_points
	import tzcp_pkg::*;
#(
	parameter int MAX_X          = DEF_MAX_X,
	parameter int MAX_Y          = DEF_MAX_Y,
	parameter int MAX_Z          = DEF_MAX_Z,
	parameter int EMPTY_SENTINEL = DEF_EMPTY_SENTINEL
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// pos_x[5:0], pos_y[11:6], pos_z[17:12], dist_value[33:18], weight_value[48:34]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// point_x[23:0], point_y[47:24], point_z[71:48]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t       cfg_q;
	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic [PT_W-1:0] point_x, point_y, point_z;

	assign cfg_ready = 1'b1;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_x  <= RST_DIM;
			cfg_q.dim_y  <= RST_DIM;
			cfg_q.dim_z  <= RST_DIM;
			cfg_q.cell_x <= RST_CELL;
			cfg_q.cell_y <= RST_CELL;
			cfg_q.cell_z <= RST_CELL;
			cfg_q.wide   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIM_X:  cfg_q.dim_x  <= cfg_data[DIM_W-1:0];
				REG_DIM_Y:  cfg_q.dim_y  <= cfg_data[DIM_W-1:0];
				REG_DIM_Z:  cfg_q.dim_z  <= cfg_data[DIM_W-1:0];
				REG_CELL_X: cfg_q.cell_x <= cfg_data;
				REG_CELL_Y: cfg_q.cell_y <= cfg_data;
				REG_CELL_Z: cfg_q.cell_z <= cfg_data;
				REG_WIDE:   cfg_q.wide   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tzcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tzcp_dp #(
		.MAX_X          (MAX_X),
		.MAX_Y          (MAX_Y),
		.MAX_Z          (MAX_Z),
		.EMPTY_SENTINEL (EMPTY_SENTINEL)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.pos_x        (s_tdata[5:0]),
		.pos_y        (s_tdata[11:6]),
		.pos_z        (s_tdata[17:12]),
		.dist_value   (s_tdata[33:18]),
		.weight_value (s_tdata[48:34]),
		.status       (status),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.last         (m_tlast)
	);

	assign m_tdata = {point_z, point_y, point_x};

endmodule

@@ src/tzcp_ctrl.sv @@
// Controller state machine of the zero-crossing point extractor.
// Depends on tzcp_pkg; drives tzcp_dp through ctrl_cmd_t and reads dp_status_t.
module tzcp_ctrl
	import tzcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_cmd,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_CEN_RD  = 13'b0000000000010,
		ST_CEN_CHK = 13'b0000000000100,
		ST_NB_RD   = 13'b0000000001000,
		ST_NB_CHK  = 13'b0000000010000,
		ST_MUL_CA  = 13'b0000000100000,
		ST_MUL_CB  = 13'b0000001000000,
		ST_MUL_NA  = 13'b0000010000000,
		ST_MUL_NB  = 13'b0000100000000,
		ST_DIV     = 13'b0001000000000,
		ST_DIV_END = 13'b0010000000000,
		ST_PUSH    = 13'b0100000000000,
		ST_FLUSH   = 13'b1000000000000
	} state_t;

	state_t            state_q, state_d;
	logic [NB_W-1:0]   nb_q, nb_d;
	logic [1:0]        axis_q, axis_d;
	logic [DCNT_W-1:0] dcnt_q, dcnt_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state, counters and datapath command.
	always_comb begin
		state_d  = state_q;
		nb_d     = nb_q;
		axis_d   = axis_q;
		dcnt_d   = dcnt_q;
		cmd.op   = OP_NONE;
		cmd.axis = axis_q;
		cmd.nb   = nb_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_SCAN) begin
						cmd.op  = OP_LOAD;
						state_d = ST_CEN_RD;
					end else begin
						cmd.op = OP_WRITE;
					end
				end
			end
			ST_CEN_RD: begin
				cmd.op  = OP_RD_CEN;
				state_d = status.interior ? ST_CEN_CHK : ST_IDLE;
			end
			ST_CEN_CHK: begin
				cmd.op = OP_CEN_LATCH;
				nb_d   = '0;
				state_d = status.centre_ok ? ST_NB_RD : ST_IDLE;
			end
			ST_NB_RD: begin
				cmd.op  = OP_RD_NB;
				state_d = ST_NB_CHK;
			end
			ST_NB_CHK: begin
				cmd.op = OP_NB_LATCH;
				if (status.crossing) begin
					axis_d  = AXIS_X;
					state_d = ST_MUL_CA;
				end else if (status.nb_last) begin
					state_d = ST_FLUSH;
				end else begin
					nb_d    = nb_q + 1'b1;
					state_d = ST_NB_RD;
				end
			end
			ST_MUL_CA: begin
				cmd.op  = OP_MUL_CA;
				state_d = ST_MUL_CB;
			end
			ST_MUL_CB: begin
				cmd.op  = OP_MUL_CB;
				state_d = ST_MUL_NA;
			end
			ST_MUL_NA: begin
				cmd.op  = OP_MUL_NA;
				state_d = ST_MUL_NB;
			end
			ST_MUL_NB: begin
				cmd.op  = OP_MUL_NB;
				dcnt_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				dcnt_d = dcnt_q + 1'b1;
				if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: begin
				cmd.op = OP_DIV_END;
				if (axis_q == AXIS_Z) begin
					state_d = ST_PUSH;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = ST_MUL_CA;
				end
			end
			ST_PUSH: begin
				// The held point moves out only once the output word is free.
				if (!status.pend_valid || status.out_free) begin
					cmd.op = OP_PUSH;
					if (status.nb_last) begin
						state_d = ST_FLUSH;
					end else begin
						nb_d    = nb_q + 1'b1;
						state_d = ST_NB_RD;
					end
				end
			end
			ST_FLUSH: begin
				if (!status.pend_valid) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.op  = OP_FLUSH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nb_q    <= '0;
			axis_q  <= AXIS_X;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			nb_q    <= nb_d;
			axis_q  <= axis_d;
			dcnt_q  <= dcnt_d;
		end
	end

endmodule

@@ src/tzcp_dp.sv @@
// Datapath of the zero-crossing point extractor: voxel memory, neighbour addressing,
// shared multiplier, restoring divider and the held and output point registers. Uses tzcp_pkg.
module tzcp_dp
	import tzcp_pkg::*;
#(
	parameter int MAX_X          = DEF_MAX_X,
	parameter int MAX_Y          = DEF_MAX_Y,
	parameter int MAX_Z          = DEF_MAX_Z,
	parameter int EMPTY_SENTINEL = DEF_EMPTY_SENTINEL
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  ctrl_cmd_t               cmd,
	input  logic [POS_W-1:0]        pos_x,
	input  logic [POS_W-1:0]        pos_y,
	input  logic [POS_W-1:0]        pos_z,
	input  logic signed [DIST_W-1:0] dist_value,
	input  logic [WGT_W-1:0]        weight_value,
	output dp_status_t              status,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PT_W-1:0]         point_x,
	output logic [PT_W-1:0]         point_y,
	output logic [PT_W-1:0]         point_z,
	output logic                    last
);

	localparam int AW_X  = $clog2(MAX_X);
	localparam int AW_Y  = $clog2(MAX_Y);
	localparam int AW_Z  = $clog2(MAX_Z);
	localparam int AW    = AW_X + AW_Y + AW_Z;
	localparam int DEPTH = 1 << AW;
	localparam int WORD_W = DIST_W + WGT_W;
	localparam int LIM_W = 10;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic [POS_W-1:0]  cx_q, cy_q, cz_q;
	logic signed [DIST_W-1:0] fc_q;
	logic [MAG_W-1:0]  magc_q, magn_q;
	logic [CRD_W-1:0]  bx_q, by_q, bz_q;
	logic [CA_W-1:0]   ca_q, cb_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [PT_W-1:0]   nx_pt_q, ny_pt_q, nz_pt_q;
	logic [PT_W-1:0]   hx_q, hy_q, hz_q;
	logic              hold_valid_q;
	logic [PT_W-1:0]   ox_q, oy_q, oz_q;
	logic              olast_q, ovalid_q;

	offset_t           off;
	logic [CRD_W-1:0]  nbx, nby, nbz;
	logic [AW-1:0]     wr_addr, cen_addr, nb_addr, rd_addr;
	logic              in_range, mem_we;
	logic signed [DIST_W-1:0] fn;
	logic [WGT_W-1:0]  wn;
	logic              usable, opposite;
	logic [LIM_W-1:0]  ex, ey, ez;
	logic [CRD_W-1:0]  ax_a, ax_b;
	logic [CELL_W-1:0] ax_cell;
	logic [CA_W-1:0]   mul_a;
	logic [MAG_W-1:0]  mul_b;
	logic [NUM_W-1:0]  prod;
	logic [DEN_W-1:0]  den;
	logic [DEN_W:0]    rem_sh, rem_diff;
	logic [PT_W-1:0]   coord_sat;
	logic              out_free, hold_to_out;

	// Neighbour coordinates from the offset table.
	always_comb begin
		off = nb_offset(cfg.wide, cmd.nb);
		nbx = {1'b0, cx_q} + {{(CRD_W-2){off.dx[1]}}, off.dx};
		nby = {1'b0, cy_q} + {{(CRD_W-2){off.dy[1]}}, off.dy};
		nbz = {1'b0, cz_q} + {{(CRD_W-2){off.dz[1]}}, off.dz};
	end

	// Memory addressing: one field per axis, x in the low bits.
	assign wr_addr  = {AW_Z'(pos_z), AW_Y'(pos_y), AW_X'(pos_x)};
	assign cen_addr = {AW_Z'(cz_q), AW_Y'(cy_q), AW_X'(cx_q)};
	assign nb_addr  = {AW_Z'(nbz), AW_Y'(nby), AW_X'(nbx)};
	assign rd_addr  = (cmd.op == OP_RD_NB) ? nb_addr : cen_addr;
	assign in_range = (LIM_W'(pos_x) < LIM_W'(MAX_X)) && (LIM_W'(pos_y) < LIM_W'(MAX_Y))
	                  && (LIM_W'(pos_z) < LIM_W'(MAX_Z));
	assign mem_we   = (cmd.op == OP_WRITE) && in_range;

	// Voxel memory, single port with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {weight_value, dist_value};
		end else begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Interior test against the clamped dimensions, voxel checks on the word just read
	// and the state of the held and output points.
	always_comb begin
		ex = (LIM_W'(cfg.dim_x) > LIM_W'(MAX_X)) ? LIM_W'(MAX_X) : LIM_W'(cfg.dim_x);
		ey = (LIM_W'(cfg.dim_y) > LIM_W'(MAX_Y)) ? LIM_W'(MAX_Y) : LIM_W'(cfg.dim_y);
		ez = (LIM_W'(cfg.dim_z) > LIM_W'(MAX_Z)) ? LIM_W'(MAX_Z) : LIM_W'(cfg.dim_z);
		fn       = rdata_q[DIST_W-1:0];
		wn       = rdata_q[WORD_W-1:DIST_W];
		usable   = (wn != '0) && (fn != DIST_W'(EMPTY_SENTINEL));
		opposite = (fc_q > 0 && fn < 0) || (fc_q < 0 && fn > 0);
		status.interior = (cx_q != '0) && (cy_q != '0)
		                  && (LIM_W'(cx_q) + LIM_W'(2) <= ex)
		                  && (LIM_W'(cy_q) + LIM_W'(2) <= ey)
		                  && (LIM_W'(cz_q) + LIM_W'(2) <= ez);
		status.centre_ok  = usable;
		status.crossing   = usable && opposite;
		status.nb_last    = cfg.wide ? (cmd.nb == NB_W'(NB_WIDE - 1))
		                             : (cmd.nb == NB_W'(NB_NARROW - 1));
		status.pend_valid = hold_valid_q;
		status.out_free   = out_free;
	end

	// Per-axis operand selection and the shared multiplier.
	always_comb begin
		case (cmd.axis)
			AXIS_X:  begin ax_a = {1'b0, cx_q}; ax_b = bx_q; ax_cell = cfg.cell_x; end
			AXIS_Y:  begin ax_a = {1'b0, cy_q}; ax_b = by_q; ax_cell = cfg.cell_y; end
			default: begin ax_a = {1'b0, cz_q}; ax_b = bz_q; ax_cell = cfg.cell_z; end
		endcase
		case (cmd.op)
			OP_MUL_CA: begin mul_a = CA_W'({ax_a, 1'b1}); mul_b = ax_cell; end
			OP_MUL_CB: begin mul_a = CA_W'({ax_b, 1'b1}); mul_b = ax_cell; end
			OP_MUL_NA: begin mul_a = ca_q; mul_b = magn_q; end
			default:   begin mul_a = cb_q; mul_b = magc_q; end
		endcase
		prod = NUM_W'(mul_a) * NUM_W'(mul_b);
	end

	// One restoring division step and the saturated quotient.
	always_comb begin
		den       = {DEN_W'(magc_q) + DEN_W'(magn_q)} << 1;
		rem_sh    = {rem_q, num_q[NUM_W-1]};
		rem_diff  = rem_sh - {1'b0, den};
		coord_sat = (num_q[NUM_W-1:PT_W] != '0) ? '1 : num_q[PT_W-1:0];
	end

	// Scan registers: position, magnitudes, products and divider.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cx_q <= pos_x;
				cy_q <= pos_y;
				cz_q <= pos_z;
			end
			OP_CEN_LATCH: begin
				fc_q   <= fn;
				magc_q <= fn[DIST_W-1] ? MAG_W'(~fn + 1'b1) : MAG_W'(fn);
			end
			OP_NB_LATCH: begin
				magn_q <= fn[DIST_W-1] ? MAG_W'(~fn + 1'b1) : MAG_W'(fn);
				bx_q   <= nbx;
				by_q   <= nby;
				bz_q   <= nbz;
			end
			OP_MUL_CA: ca_q <= prod[CA_W-1:0];
			OP_MUL_CB: cb_q <= prod[CA_W-1:0];
			OP_MUL_NA: num_q <= prod;
			OP_MUL_NB: begin
				num_q <= num_q + prod;
				rem_q <= '0;
			end
			OP_DIV: begin
				if (!rem_diff[DEN_W]) begin
					rem_q <= rem_diff[DEN_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DEN_W-1:0];
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			OP_DIV_END: begin
				case (cmd.axis)
					AXIS_X:  nx_pt_q <= coord_sat;
					AXIS_Y:  ny_pt_q <= coord_sat;
					default: nz_pt_q <= coord_sat;
				endcase
			end
			default: ;
		endcase
	end

	// Held point and output word. A point is held until the next crossing or
	// the end of the scan decides its last flag.
	assign out_free    = !ovalid_q || out_ready;
	assign hold_to_out = hold_valid_q && ((cmd.op == OP_PUSH) || (cmd.op == OP_FLUSH));

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUSH) begin
			hx_q <= nx_pt_q;
			hy_q <= ny_pt_q;
			hz_q <= nz_pt_q;
		end
		if (hold_to_out) begin
			ox_q    <= hx_q;
			oy_q    <= hy_q;
			oz_q    <= hz_q;
			olast_q <= (cmd.op == OP_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			ovalid_q     <= 1'b0;
		end else begin
			if (cmd.op == OP_PUSH) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.op == OP_FLUSH) begin
				hold_valid_q <= 1'b0;
			end
			if (hold_to_out) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign point_x   = ox_q;
	assign point_y   = oy_q;
	assign point_z   = oz_q;
	assign last      = olast_q;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for tsdf_zero_crossing_points: voxel loads and scans in
// several register settings, every surface point checked against a predictor.
// Depends on tzcp_pkg and the RTL under src only.
module testbench;
	import tzcp_pkg::*;

	localparam int STORE_DEPTH = 64 * 64 * 64;
	localparam int DRAIN_CYCLES = 80;
	localparam int RUN_LIMIT = 60_000_000;

	// Forward offsets: entries 0..2 are the axis set, 3..15 the thirteen-neighbour set.
	localparam int OFF_X [16] = '{1, 0, 0, -1, 0, 1, -1, 0, 1, -1, 0, 1, -1, -1, 0, 1};
	localparam int OFF_Y [16] = '{0, 1, 0, -1, -1, -1, 0, 0, 0, 1, 1, 1, 0, 1, 1, 1};
	localparam int OFF_Z [16] = '{0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0};

	typedef struct {
		logic [PT_W-1:0] px;
		logic [PT_W-1:0] py;
		logic [PT_W-1:0] pz;
		logic            last;
	} surf_point_t;

	typedef struct {
		logic                     cmd;
		int                       x;
		int                       y;
		int                       z;
		logic signed [DIST_W-1:0] dval;
		logic [WGT_W-1:0]         wgt;
		int                       n_pts;   // -1 leaves the count to the predictor
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predictor state: voxel copy, which voxels were loaded, register copies.
	logic [31:0]     voxel_mem [STORE_DEPTH];
	bit              loaded [STORE_DEPTH];
	int              dim_x, dim_y, dim_z;
	int              cell_x, cell_y, cell_z;
	bit              wide_mode;
	surf_point_t     points_due [$];
	int              fail_count;
	int              hold_request;
	bit              calm;

	tsdf_zero_crossing_points dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Run limit, far beyond the slowest correct run.
	initial begin
		#RUN_LIMIT;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic int voxel_addr(input int x, input int y, input int z);
		return x + 64 * (y + 64 * z);
	endfunction

	function automatic bit voxel_usable(input logic [31:0] w);
		return w[30:16] != '0 && $signed(w[15:0]) != 16'sd32767;
	endfunction

	function automatic int clamp64(input int d);
		return d > 64 ? 64 : d;
	endfunction

	function automatic bit in_interior(input int x, input int y, input int z);
		return x >= 1 && x + 2 <= clamp64(dim_x) && y >= 1 && y + 2 <= clamp64(dim_y)
			&& z + 2 <= clamp64(dim_z);
	endfunction

	// A scan is safe when it stays outside the interior or every voxel it may read was loaded.
	function automatic bit scan_safe(input int x, input int y, input int z);
		if (!in_interior(x, y, z))
			return 1;
		for (int dz = 0; dz <= 1; dz++)
			for (int dy = -1; dy <= 1; dy++)
				for (int dx = -1; dx <= 1; dx++)
					if (!loaded[voxel_addr(x + dx, y + dy, z + dz)])
						return 0;
		return 1;
	endfunction

	// Point on one axis between two voxel centres, truncated and saturated.
	function automatic logic [PT_W-1:0] centre_interp(input int a, input int b,
			input int edge_len, input int mag_a, input int mag_b);
		longint unsigned ca, cb, num, den, q;
		ca = longint'(2 * a + 1) * edge_len;
		cb = longint'(2 * b + 1) * edge_len;
		num = ca * mag_b + cb * mag_a;
		den = 2 * (longint'(mag_a) + mag_b);
		q = num / den;
		return q > 64'd16777215 ? 24'hFFFFFF : q[PT_W-1:0];
	endfunction

	// Update the voxel copy or queue the points a scan must produce.
	task automatic predict_word(input logic cmd, input int x, input int y, input int z,
			input logic signed [DIST_W-1:0] d, input logic [WGT_W-1:0] w, output int n);
		surf_point_t found [$];
		surf_point_t p;
		logic [31:0] cw, nw;
		int fc, fn, mc, first, cnt;
		n = 0;
		if (cmd == CMD_WRITE) begin
			voxel_mem[voxel_addr(x, y, z)] = {1'b0, w, d};
			loaded[voxel_addr(x, y, z)] = 1;
			return;
		end
		if (!in_interior(x, y, z))
			return;
		cw = voxel_mem[voxel_addr(x, y, z)];
		if (!voxel_usable(cw))
			return;
		fc = $signed(cw[15:0]);
		mc = fc < 0 ? -fc : fc;
		first = wide_mode ? 3 : 0;
		cnt = wide_mode ? NB_WIDE : NB_NARROW;
		for (int i = first; i < first + cnt; i++) begin
			nw = voxel_mem[voxel_addr(x + OFF_X[i], y + OFF_Y[i], z + OFF_Z[i])];
			fn = $signed(nw[15:0]);
			if (voxel_usable(nw) && ((fc > 0 && fn < 0) || (fc < 0 && fn > 0))) begin
				p.px = centre_interp(x, x + OFF_X[i], cell_x, mc, fn < 0 ? -fn : fn);
				p.py = centre_interp(y, y + OFF_Y[i], cell_y, mc, fn < 0 ? -fn : fn);
				p.pz = centre_interp(z, z + OFF_Z[i], cell_z, mc, fn < 0 ? -fn : fn);
				p.last = 0;
				found = {found, p};
			end
		end
		n = found.size();
		if (n > 0)
			found[n - 1].last = 1;
		foreach (found[k])
			points_due = {points_due, found[k]};
	endtask

	// Offer one input word and predict it once it is taken.
	task automatic send_word(input logic cmd, input int x, input int y, input int z,
			input logic signed [DIST_W-1:0] d, input logic [WGT_W-1:0] w, output int n);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, w, d, z[5:0], y[5:0], x[5:0]};
		do @(posedge clk); while (!s_tready);
		predict_word(cmd, x, y, z, d, w, n);
	endtask

	// Sender gap: mostly none or short, a few long.
	task automatic sender_gap();
		int r, g;
		r = $urandom_range(0, 99);
		g = 0;
		if (!calm)
			g = r < 60 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(5, 40));
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		while (points_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DIM_X:  dim_x = val & 8'h7F;
			REG_DIM_Y:  dim_y = val & 8'h7F;
			REG_DIM_Z:  dim_z = val & 8'h7F;
			REG_CELL_X: cell_x = val & 16'hFFFF;
			REG_CELL_Y: cell_y = val & 16'hFFFF;
			REG_CELL_Z: cell_z = val & 16'hFFFF;
			default:    wide_mode = val[0];
		endcase
	endtask

	task automatic set_phase(input int dx, input int dy, input int dz, input int cx,
			input int cy, input int cz, input int wide);
		drain();
		write_reg(REG_DIM_X, dx);
		write_reg(REG_DIM_Y, dy);
		write_reg(REG_DIM_Z, dz);
		write_reg(REG_CELL_X, cx);
		write_reg(REG_CELL_Y, cy);
		write_reg(REG_CELL_Z, cz);
		write_reg(REG_WIDE, wide);
	endtask

	function automatic logic signed [DIST_W-1:0] rand_dist();
		int m;
		m = $urandom_range(1, 2000);
		case ($urandom_range(0, 9))
			0: return 16'sd0;
			1: return 16'sd32767;
			2: return 16'sh8000;
			3: return DIST_W'($urandom_range(0, 65535));
			default: return DIST_W'($urandom_range(0, 1) ? m : -m);
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 15'h7FFF;
			2: return WGT_W'($urandom_range(0, 32767));
			default: return WGT_W'($urandom_range(1, 100));
		endcase
	endfunction

	// Load the 4x4x3 corner block that all region scans read from.
	task automatic load_block(input bit pattern);
		int n;
		for (int z = 0; z < 3; z++)
			for (int y = 0; y < 4; y++)
				for (int x = 0; x < 4; x++) begin
					sender_gap();
					if (pattern)
						send_word(CMD_WRITE, x, y, z, (x + y + z) % 2 ? -16'sd100 : 16'sd200,
							15'd1, n);
					else
						send_word(CMD_WRITE, x, y, z, rand_dist(), rand_weight(), n);
				end
	endtask

	// One random phase: block scans dominate, with rewrites, far writes and stray scans.
	task automatic random_items(input int count);
		int r, x, y, z, n;
		for (int i = 0; i < count; i++) begin
			sender_gap();
			r = $urandom_range(0, 99);
			x = $urandom_range(0, 63);
			y = $urandom_range(0, 63);
			z = $urandom_range(0, 63);
			if (r < 3)
				drain();
			if (r < 45 || (r >= 70 && r < 85 && !scan_safe(x, y, z)))
				send_word(CMD_SCAN, $urandom_range(1, 2), $urandom_range(1, 2),
					$urandom_range(0, 1), rand_dist(), rand_weight(), n);
			else if (r < 70 && r >= 60)
				send_word(CMD_WRITE, x, y, z, rand_dist(), rand_weight(), n);
			else if (r >= 70 && r < 85)
				send_word(CMD_SCAN, x, y, z, rand_dist(), rand_weight(), n);
			else
				send_word(CMD_WRITE, $urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 2), rand_dist(), rand_weight(), n);
		end
	endtask

	// Receiver readiness, with random stalls and requested long hold-offs.
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			r = $urandom_range(0, 99);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (calm || r < 70) begin
				m_tready <= 1'b1;
			end else begin
				stall_left = r < 95 ? $urandom_range(0, 2) : $urandom_range(20, 60);
				m_tready <= 1'b0;
			end
		end
	end

	// Compare each accepted point word with the oldest expected point.
	always @(posedge clk) begin
		surf_point_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (points_due.size() == 0) begin
				report_mismatch($sformatf("unexpected point word %h", m_tdata));
			end else begin
				e = points_due.pop_front();
				if (m_tdata[23:0] !== e.px)
					report_mismatch($sformatf("point_x %h, expected %h", m_tdata[23:0], e.px));
				if (m_tdata[47:24] !== e.py)
					report_mismatch($sformatf("point_y %h, expected %h", m_tdata[47:24], e.py));
				if (m_tdata[71:48] !== e.pz)
					report_mismatch($sformatf("point_z %h, expected %h", m_tdata[71:48], e.pz));
				if (m_tlast !== e.last)
					report_mismatch($sformatf("last %b, expected %b", m_tlast, e.last));
			end
		end
	end

	// Directed rows run against the checkerboard block in axis mode.
	stim_row_t directed [] = '{
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     3},
		'{CMD_SCAN,   0,  1,  1,  16'sd0,      15'd0,     0},
		'{CMD_SCAN,   63, 63, 63, 16'sd0,      15'd0,     0},
		'{CMD_SCAN,   1,  0,  0,  16'sd0,      15'd0,     0},
		'{CMD_SCAN,   1,  1,  63, 16'sd0,      15'd0,     0},
		'{CMD_WRITE,  2,  1,  0,  16'sd32767,  15'd5,     0},
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     2},
		'{CMD_WRITE,  1,  2,  0,  16'sd0,      15'd5,     0},
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     1},
		'{CMD_WRITE,  1,  1,  1,  -16'sd100,   15'd0,     0},
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     0},
		'{CMD_WRITE,  1,  1,  0,  16'sh8000,   15'h7FFF,  0},
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     0},
		'{CMD_WRITE,  2,  1,  0,  16'sd32766,  15'h7FFF,  0},
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     1},
		'{CMD_WRITE,  1,  1,  0,  16'sd32767,  15'd9,     0},
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     0},
		'{CMD_WRITE,  1,  1,  0,  16'sd5,      15'd0,     0},
		'{CMD_SCAN,   1,  1,  0,  16'sd0,      15'd0,     0},
		'{CMD_WRITE,  63, 63, 63, -16'sd1,     15'd1,     0},
		'{CMD_SCAN,   2,  2,  1,  16'sd0,      15'd0,    -1},
		'{CMD_SCAN,   2,  1,  1,  16'sd0,      15'd0,    -1}
	};

	initial begin
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		hold_request = 0;
		calm = 0;
		dim_x = RST_DIM;
		dim_y = RST_DIM;
		dim_z = RST_DIM;
		cell_x = RST_CELL;
		cell_y = RST_CELL;
		cell_z = RST_CELL;
		wide_mode = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings.
		load_block(1);
		foreach (directed[i]) begin
			sender_gap();
			send_word(directed[i].cmd, directed[i].x, directed[i].y, directed[i].z,
				directed[i].dval, directed[i].wgt, n);
			if (directed[i].n_pts >= 0 && n != directed[i].n_pts)
				report_mismatch($sformatf("row %0d predicts %0d points, table says %0d",
					i, n, directed[i].n_pts));
		end
		drain();
		random_items(15);

		// Smallest volume, widest cells, thirteen neighbours.
		set_phase(3, 3, 2, 65535, 65535, 65535, 1);
		random_items(15);

		// Oversized dims, zero cells, axis neighbours.
		set_phase(127, 127, 127, 0, 0, 0, 0);
		random_items(15);

		// No idling on either side.
		set_phase(4, 5, 3, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), 1);
		calm = 1;
		random_items(15);
		calm = 0;

		// Long receiver hold-off while scans keep coming.
		set_phase(64, 64, 64, 1, 1, 1, 1);
		hold_request = 400;
		random_items(15);

		set_phase($urandom_range(3, 64), $urandom_range(3, 64), $urandom_range(2, 64),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
		random_items(10);

		drain();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
